// ===== design/gaussian_2d_density_assert.svh =====
// ----------------------------------------------------------------------------
// gaussian_2d_density assertion macros
// Shorthands for clocked properties checked under the block's reset.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_2D_DENSITY_ASSERT_SVH
`define GAUSSIAN_2D_DENSITY_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define GD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define GD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/gd2d_pkg.sv =====
// ----------------------------------------------------------------------------
// gd2d_pkg
// Widths, fixed-point constants and the 2^-f table of the 2D Gaussian block.
// ----------------------------------------------------------------------------
package gd2d_pkg;

	localparam int COORD_BITS        = 12;
	localparam int EXP_TABLE_ENTRIES = 256;
	localparam int EXP_IDX_W         = $clog2(EXP_TABLE_ENTRIES);

	localparam int PIPE_STAGES = 12;

	localparam int COV_W  = 32;
	localparam int GAIN_W = 16;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int TERM_W = COV_W + SQ_W;
	localparam int ACC_W  = (TERM_W > 61) ? TERM_W + 1 : 62;
	localparam int H_W    = ACC_W + 2;
	localparam int HC_W   = 31;
	localparam int LOG2E_W = 32;
	localparam int Z_W    = HC_W + LOG2E_W;
	localparam int ZF_LSB = 25;
	localparam int ZI_LSB = 55;
	localparam int ZI_W   = Z_W - ZI_LSB;
	localparam int FRAC_W = 30;
	localparam int TAB_W  = 31;
	localparam int VAL_W  = TAB_W - 6;
	localparam int INV2PI_W = 30;
	localparam int BASE_W = GAIN_W + INV2PI_W - 8;
	localparam int PL_W   = 32 + VAL_W;
	localparam int PH_W   = BASE_W - 32 + VAL_W;
	localparam int P_W    = BASE_W + VAL_W;
	localparam int SH_PAD = 16;
	localparam int SH_BIAS = 32 + SH_PAD;
	localparam int SH_W   = 7;
	localparam int WIDE_W = P_W + SH_PAD;

	localparam logic signed [LOG2E_W-1:0] LOG2E_Q30 = 32'sd1549082005;
	localparam logic [INV2PI_W-1:0] INV2PI_Q32 = 30'd683565276;
	localparam longint unsigned LN2_Q30 = 64'd744261118;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	localparam logic signed [ACC_W-1:0] TERM_MAX = ACC_W'(1) << 60;
	localparam logic signed [ACC_W-1:0] TERM_MIN = -TERM_MAX;
	localparam logic signed [H_W-1:0] H_LIMIT = H_W'(1) << 30;
	localparam logic signed [H_W-1:0] H_FLOOR = -H_LIMIT;
	localparam logic signed [HC_W-1:0] HC_MIN = {1'b1, {(HC_W-1){1'b0}}};

	typedef enum logic [2:0] {
		CFG_INV_COV_XX = 3'd0,
		CFG_INV_COV_XY = 3'd1,
		CFG_INV_COV_YY = 3'd2,
		CFG_CENTER_X   = 3'd3,
		CFG_CENTER_Y   = 3'd4,
		CFG_GAIN       = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic adv_s7;
		logic adv_s8;
		logic adv_s9;
	} interp_ctl_t;

	typedef logic [TAB_W-1:0] exp_tab_t [0:EXP_TABLE_ENTRIES];

	// truncating quotient num/den by restoring shift-subtract
	function automatic longint unsigned tab_quot(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// 2^-f in Q.30 at f = k/ENTRIES, 16-term truncated series of exp(-f*ln2)
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		longint unsigned x;
		longint unsigned term;
		longint sum;
		for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
			x = (LN2_Q30 * longint'(k)) / EXP_TABLE_ENTRIES;
			term = ONE_Q30;
			sum = longint'(ONE_Q30);
			for (int n = 1; n <= 16; n++) begin
				term = tab_quot((term * x) >> 30, 64'(n));
				if ((n % 2) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			tab[k] = TAB_W'(sum);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	function automatic logic signed [ACC_W-1:0] clamp_term(input logic signed [ACC_W-1:0] t);
		if (t > TERM_MAX) begin
			return TERM_MAX;
		end else if (t < TERM_MIN) begin
			return TERM_MIN;
		end
		return t;
	endfunction

endpackage

// ===== design/gd2d_interp.sv =====
// ----------------------------------------------------------------------------
// gd2d_interp
// Three-stage 2^-f lookup with linear interpolation, result in Q.24.
// ----------------------------------------------------------------------------
module gd2d_interp (
	input  logic                                  clk,
	input  gd2d_pkg::interp_ctl_t                 ctl,
	input  logic [gd2d_pkg::FRAC_W-1:0]           frac,
	output logic [gd2d_pkg::VAL_W-1:0]            val
);

	localparam int IW = gd2d_pkg::EXP_IDX_W;
	localparam int FW = gd2d_pkg::FRAC_W;
	localparam int TW = gd2d_pkg::TAB_W;

	logic [IW:0]      idx;
	logic [TW-1:0]    lo_ent;
	logic [TW-1:0]    hi_ent;
	logic [TW-1:0]    a_s7;
	logic [TW-1:0]    diff_s7;
	logic [FW-1:0]    rem_s7;
	logic [TW-1:0]    a_s8;
	logic [TW+FW-1:0] prod_s8;
	logic [TW-1:0]    sub;
	logic [gd2d_pkg::VAL_W-1:0] val_s9;

	assign idx    = (IW+1)'(frac[FW-1 -: IW]);
	assign lo_ent = gd2d_pkg::EXP_TAB[idx];
	assign hi_ent = gd2d_pkg::EXP_TAB[idx + (IW+1)'(1)];
	assign sub    = a_s8 - prod_s8[TW+FW-1:FW];

	always_ff @(posedge clk) begin
		if (ctl.adv_s7) begin
			a_s7    <= lo_ent;
			diff_s7 <= lo_ent - hi_ent;
			rem_s7  <= {frac[FW-IW-1:0], IW'(0)};
		end
		if (ctl.adv_s8) begin
			a_s8    <= a_s7;
			prod_s8 <= (TW+FW)'(diff_s7) * (TW+FW)'(rem_s7);
		end
		if (ctl.adv_s9) begin
			val_s9 <= sub[TW-1:6];
		end
	end

	assign val = val_s9;

endmodule

// ===== design/gaussian_2d_density.sv =====
// ----------------------------------------------------------------------------
// gaussian_2d_density
// Bivariate Gaussian value gain/(2*pi)*exp(-q/2) per pixel coordinate.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, pix_x, pix_y): one pixel coordinate per
//    transaction. Output channel (out_valid/out_ready, density): one Q8.24
//    result per input transaction, in order.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is
//    always high; index 0..5 selects inv_cov_xx, inv_cov_xy, inv_cov_yy,
//    center_x, center_y, gain. Other indexes are dropped. Write only while
//    the pipeline is empty.
//  - out_valid rises when the transaction reaches the last stage (S12);
//    one transaction per cycle while out_ready stays high.
//  - Each stage holds a valid bit; a stage loads when it is empty or the
//    stage after it moves, so bubbles squeeze out under output backpressure.
//    When out_ready is low and all stages are full, in_ready drops.
//  - Reset empties the pipeline and loads the registers with their defaults
//    (identity inverse covariance, center 255/255, gain 5.0).
//  - Results with q/2 >= 32 are zero; large values saturate at all ones.
// ----------------------------------------------------------------------------
module gaussian_2d_density (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [2:0]                      cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [gd2d_pkg::COORD_BITS-1:0] pix_x,
	input  logic [gd2d_pkg::COORD_BITS-1:0] pix_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [31:0]                     density
);

`include "gaussian_2d_density_assert.svh"

	localparam int NS = gd2d_pkg::PIPE_STAGES;
	localparam int CB = gd2d_pkg::COORD_BITS;

	// configuration registers
	logic signed [31:0] cov_xx_q;
	logic signed [31:0] cov_xy_q;
	logic signed [31:0] cov_yy_q;
	logic [CB-1:0]      center_x_q;
	logic [CB-1:0]      center_y_q;
	logic [gd2d_pkg::GAIN_W-1:0] gain_q;

	// pipeline control
	logic [NS:1]   vld_q;
	logic [NS+1:1] rdy;

	// S1: offsets and base scale
	logic signed [gd2d_pkg::DIFF_W-1:0] dx_s1, dy_s1;
	logic [gd2d_pkg::BASE_W-1:0] base_s1, base_s2, base_s3, base_s4, base_s5;
	logic [gd2d_pkg::BASE_W-1:0] base_s6, base_s7, base_s8, base_s9;
	logic [gd2d_pkg::GAIN_W+gd2d_pkg::INV2PI_W-1:0] gain_prod;
	// S2: squares
	logic signed [gd2d_pkg::SQ_W-1:0] sqxx_s2, sqxy_s2, sqyy_s2;
	// S3: weighted terms
	logic signed [gd2d_pkg::TERM_W-1:0] t1_s3, t2_s3, t3_s3;
	// S4: clamped sum, h = q/2 in Q.25
	logic signed [gd2d_pkg::ACC_W-1:0] c1, c2, c3;
	logic signed [gd2d_pkg::H_W-1:0]   h_s4;
	// S5: range check
	logic far_s5, far_s6, far_s7, far_s8, far_s9, far_s10, far_s11;
	logic signed [gd2d_pkg::HC_W-1:0] hc_s5;
	// S6: z = h*log2(e) in Q.55
	logic signed [gd2d_pkg::Z_W-1:0]  z;
	logic signed [gd2d_pkg::ZI_W-1:0] zi_s6;
	logic [gd2d_pkg::FRAC_W-1:0]      frac_s6;
	// S7..S11: shift amount rides along
	logic [gd2d_pkg::SH_W-1:0] sh_s7, sh_s8, sh_s9, sh_s10, sh_s11;
	logic [gd2d_pkg::ZI_W-1:0] sh_sum;
	// S7..S9: interpolation
	gd2d_pkg::interp_ctl_t      ictl;
	logic [gd2d_pkg::VAL_W-1:0] val_s9;
	// S10/S11: product
	logic [gd2d_pkg::PL_W-1:0] pl_s10;
	logic [gd2d_pkg::PH_W-1:0] ph_s10;
	logic [gd2d_pkg::P_W-1:0]  p_s11;
	// S12: shift and saturate
	logic [gd2d_pkg::WIDE_W-1:0] wide;
	logic [31:0] dens_s12;

	// ------------------------------------------------------------------
	// Config writes
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_xx_q   <= 32'sd16777216;
			cov_xy_q   <= 32'sd0;
			cov_yy_q   <= 32'sd16777216;
			center_x_q <= CB'(255);
			center_y_q <= CB'(255);
			gain_q     <= 16'd1280;
		end else if (cfg_valid && cfg_ready) begin
			unique case (gd2d_pkg::cfg_reg_t'(cfg_index))
				gd2d_pkg::CFG_INV_COV_XX: cov_xx_q   <= cfg_data;
				gd2d_pkg::CFG_INV_COV_XY: cov_xy_q   <= cfg_data;
				gd2d_pkg::CFG_INV_COV_YY: cov_yy_q   <= cfg_data;
				gd2d_pkg::CFG_CENTER_X:   center_x_q <= cfg_data[CB-1:0];
				gd2d_pkg::CFG_CENTER_Y:   center_y_q <= cfg_data[CB-1:0];
				gd2d_pkg::CFG_GAIN:       gain_q     <= cfg_data[gd2d_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline handshake: a stage loads when empty or when it drains
	// ------------------------------------------------------------------
	assign rdy[NS+1] = out_ready;
	assign rdy[NS:1] = ~vld_q | rdy[NS+1:2];
	assign in_ready  = rdy[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (rdy[NS:1] & {vld_q[NS-1:1], in_valid}) | (~rdy[NS:1] & vld_q);
		end
	end

	// ------------------------------------------------------------------
	// Datapath
	// ------------------------------------------------------------------
	assign gain_prod = (gd2d_pkg::GAIN_W+gd2d_pkg::INV2PI_W)'(gain_q)
		* (gd2d_pkg::GAIN_W+gd2d_pkg::INV2PI_W)'(gd2d_pkg::INV2PI_Q32);

	// products clamped to +-2^60 (Q.24) before the sum; the cross term counts twice
	assign c1 = gd2d_pkg::clamp_term(gd2d_pkg::ACC_W'(t1_s3));
	assign c2 = gd2d_pkg::clamp_term(gd2d_pkg::ACC_W'(t2_s3));
	assign c3 = gd2d_pkg::clamp_term(gd2d_pkg::ACC_W'(t3_s3));

	assign z = gd2d_pkg::Z_W'(hc_s5) * gd2d_pkg::Z_W'(gd2d_pkg::LOG2E_Q30);

	// integer part of z plus bias; always in 1..94 after the h clamp
	assign sh_sum = zi_s6 + gd2d_pkg::ZI_W'(gd2d_pkg::SH_BIAS);

	// padded right shift covers both the down shift and a left shift up to 16
	assign wide = {p_s11, gd2d_pkg::SH_PAD'(0)} >> sh_s11;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			dx_s1   <= $signed({1'b0, pix_x}) - $signed({1'b0, center_x_q});
			dy_s1   <= $signed({1'b0, pix_y}) - $signed({1'b0, center_y_q});
			base_s1 <= gain_prod[gd2d_pkg::GAIN_W+gd2d_pkg::INV2PI_W-1:8];
		end
		if (rdy[2]) begin
			sqxx_s2 <= gd2d_pkg::SQ_W'(dx_s1) * gd2d_pkg::SQ_W'(dx_s1);
			sqxy_s2 <= gd2d_pkg::SQ_W'(dx_s1) * gd2d_pkg::SQ_W'(dy_s1);
			sqyy_s2 <= gd2d_pkg::SQ_W'(dy_s1) * gd2d_pkg::SQ_W'(dy_s1);
			base_s2 <= base_s1;
		end
		if (rdy[3]) begin
			t1_s3   <= gd2d_pkg::TERM_W'(cov_xx_q) * gd2d_pkg::TERM_W'(sqxx_s2);
			t2_s3   <= gd2d_pkg::TERM_W'(cov_xy_q) * gd2d_pkg::TERM_W'(sqxy_s2);
			t3_s3   <= gd2d_pkg::TERM_W'(cov_yy_q) * gd2d_pkg::TERM_W'(sqyy_s2);
			base_s3 <= base_s2;
		end
		if (rdy[4]) begin
			h_s4    <= gd2d_pkg::H_W'(c1) + (gd2d_pkg::H_W'(c2) <<< 1) + gd2d_pkg::H_W'(c3);
			base_s4 <= base_s3;
		end
		if (rdy[5]) begin
			far_s5  <= (h_s4 >= gd2d_pkg::H_LIMIT);
			hc_s5   <= (h_s4 < gd2d_pkg::H_FLOOR) ? gd2d_pkg::HC_MIN
				: h_s4[gd2d_pkg::HC_W-1:0];
			base_s5 <= base_s4;
		end
		if (rdy[6]) begin
			zi_s6   <= z[gd2d_pkg::Z_W-1:gd2d_pkg::ZI_LSB];
			frac_s6 <= z[gd2d_pkg::ZI_LSB-1:gd2d_pkg::ZF_LSB];
			far_s6  <= far_s5;
			base_s6 <= base_s5;
		end
		if (rdy[7]) begin
			sh_s7   <= sh_sum[gd2d_pkg::SH_W-1:0];
			far_s7  <= far_s6;
			base_s7 <= base_s6;
		end
		if (rdy[8]) begin
			sh_s8   <= sh_s7;
			far_s8  <= far_s7;
			base_s8 <= base_s7;
		end
		if (rdy[9]) begin
			sh_s9   <= sh_s8;
			far_s9  <= far_s8;
			base_s9 <= base_s8;
		end
		if (rdy[10]) begin
			pl_s10  <= gd2d_pkg::PL_W'(base_s9[31:0]) * gd2d_pkg::PL_W'(val_s9);
			ph_s10  <= gd2d_pkg::PH_W'(base_s9[gd2d_pkg::BASE_W-1:32])
				* gd2d_pkg::PH_W'(val_s9);
			sh_s10  <= sh_s9;
			far_s10 <= far_s9;
		end
		if (rdy[11]) begin
			p_s11   <= gd2d_pkg::P_W'(pl_s10) + (gd2d_pkg::P_W'(ph_s10) << 32);
			sh_s11  <= sh_s10;
			far_s11 <= far_s10;
		end
		if (rdy[12]) begin
			if (far_s11) begin
				dens_s12 <= '0;
			end else if (|wide[gd2d_pkg::WIDE_W-1:32]) begin
				dens_s12 <= '1;
			end else begin
				dens_s12 <= wide[31:0];
			end
		end
	end

	assign density = dens_s12;

	// 2^-frac lookup, stages 7..9
	assign ictl.adv_s7 = rdy[7];
	assign ictl.adv_s8 = rdy[8];
	assign ictl.adv_s9 = rdy[9];

	gd2d_interp u_interp (
		.clk  (clk),
		.ctl  (ictl),
		.frac (frac_s6),
		.val  (val_s9)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`GD_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_q[1], "accepted transaction missing from stage 1")
	`GD_ASSERT_SAME(a_block_only_full, !in_ready, &vld_q, "input blocked with a pipeline bubble")
	`GD_ASSERT_SAME(a_idle_out_ready, !out_valid, in_ready, "input blocked while output stage empty")

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: gaussian_2d_density testbench
// Streams pixel coordinates through the density pipeline. Every input
// transaction is scored against a bit-exact fixed-point predictor kept in
// step with the configuration writes. Results are checked in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Fixed-point constants of the density math (Q.30 / Q.32 / Q.24 scaling).
	localparam int          TAB_ENTRIES = 256;
	localparam logic [63:0] LN2_Q30     = 64'd744261118;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] INV2PI_Q32  = 64'd683565276;
	localparam longint      LOG2E_Q30   = 64'sd1549082005;
	// q/2 in Q.25 at which the output is forced to zero (q/2 = 32)
	localparam longint      H_CUTOFF    = 64'sd1073741824;
	// offset that keeps z positive before the integer/fraction split
	localparam longint      Z_BIAS      = 64'sh2000_0000_0000_0000;
	// each quadratic-form product is limited to +-2^60 before summing
	localparam longint      TERM_LIMIT  = 64'sh1000_0000_0000_0000;

	// Config indexes outside the register map; the block drops them.
	localparam logic [2:0] CFG_SPARE_6 = 3'd6;
	localparam logic [2:0] CFG_SPARE_7 = 3'd7;

	typedef struct {
		logic [11:0] x;
		logic [11:0] y;
		logic [31:0] density;
	} density_exp_t;

	// ------------------------------------------------------------------------
	// DUT signals; all inputs start at known values
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [31:0] cfg_data  = 32'd0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [11:0] pix_x     = 12'd0;
	logic [11:0] pix_y     = 12'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] density;

	// Shadow copy of the configuration registers, reset values.
	logic signed [31:0] cov_xx = 32'sd16777216;
	logic signed [31:0] cov_xy = 32'sd0;
	logic signed [31:0] cov_yy = 32'sd16777216;
	logic [11:0]        ctr_x  = 12'd255;
	logic [11:0]        ctr_y  = 12'd255;
	logic [15:0]        gain_q = 16'd1280;

	// 2^-f table in Q.30, one extra entry for interpolation at the top
	logic [63:0] exp_tab [0:TAB_ENTRIES];

	density_exp_t density_q[$];   // predicted results, oldest first
	int           errors = 0;

	// Idling knobs: 0 = never idle, n = idle on roughly one in n chances.
	int gap_rate   = 4;
	int stall_rate = 6;
	int stall_left = 0;
	bit quiet      = 1'b0;        // final stretch: no idling on either side

	always #5 clk = ~clk;

	gaussian_2d_density u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pix_x     (pix_x),
		.pix_y     (pix_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.density   (density)
	);

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// 2^-f at f = k/ENTRIES via a 16-term truncated series of exp(-f*ln2).
	function automatic void fill_exp_table();
		logic [63:0] x;
		logic [63:0] term;
		longint      sum;
		for (int k = 0; k <= TAB_ENTRIES; k++) begin
			x = (LN2_Q30 * k) / TAB_ENTRIES;
			term = ONE_Q30;
			sum = longint'(ONE_Q30);
			for (int n = 1; n <= 16; n++) begin
				term = ((term * x) >> 30) / n;
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			exp_tab[k] = sum;
		end
	endfunction

	function automatic longint limit_term(input longint t);
		if (t > TERM_LIMIT) begin
			return TERM_LIMIT;
		end
		if (t < -TERM_LIMIT) begin
			return -TERM_LIMIT;
		end
		return t;
	endfunction

	// gain/(2*pi) * 2^-(q/2 * log2 e), Q8.24, saturated
	function automatic logic [31:0] predict_density(input logic [11:0] px,
			input logic [11:0] py);
		longint      dx, dy, h, shift;
		logic [63:0] zu, frac, pos, rem, val, base, p;
		int          idx;
		dx = longint'(px) - longint'(ctr_x);
		dy = longint'(py) - longint'(ctr_y);
		// q in Q.24 is the same integer as h = q/2 in Q.25
		h = limit_term(longint'(cov_xx) * (dx * dx))
			+ 2 * limit_term(longint'(cov_xy) * (dx * dy))
			+ limit_term(longint'(cov_yy) * (dy * dy));
		if (h >= H_CUTOFF) begin
			return 32'd0;
		end
		if (h < -H_CUTOFF) begin
			h = -H_CUTOFF;
		end
		zu = h * LOG2E_Q30 + Z_BIAS;            // z in Q.55, biased by 64
		frac = {34'd0, zu[54:25]};
		shift = longint'(zu[63:55]) - 32;
		pos = frac * TAB_ENTRIES;
		idx = int'(pos >> 30);
		rem = {34'd0, pos[29:0]};
		val = exp_tab[idx] - (((exp_tab[idx] - exp_tab[idx + 1]) * rem) >> 30);
		val = val >> 6;                         // Q.24
		base = ({48'd0, gain_q} * INV2PI_Q32) >> 8;  // Q.32
		p = base * val;                         // Q.56
		if (shift >= 64) begin
			return 32'd0;
		end
		if (shift >= 0) begin
			p = p >> shift;
			return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
		end
		if (p == 64'd0) begin
			return 32'd0;
		end
		if (p > (64'hFFFF_FFFF >> (-shift))) begin
			return 32'hFFFF_FFFF;
		end
		p = p << (-shift);
		return p[31:0];
	endfunction

	// ------------------------------------------------------------------------
	// Shared drivers. Inputs move on the falling edge; handshakes are
	// sampled on the rising edge, before any flop in the block updates.
	// ------------------------------------------------------------------------

	// One input transaction; the expectation is queued at the accepting edge.
	task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
		density_exp_t item;
		int           gap;
		gap = 0;
		if (!quiet && gap_rate != 0 && $urandom_range(0, gap_rate - 1) == 0) begin
			gap = $urandom_range(1, 15);
		end
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pix_x    <= x;
		pix_y    <= y;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		item.x = x;
		item.y = y;
		item.density = predict_density(x, y);
		density_q.push_back(item);
	endtask

	// Sender holds off until every outstanding result has been checked.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (density_q.size() != 0) @(negedge clk);
	endtask

	// One config write transaction; the shadow registers follow at the edge.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			gd2d_pkg::CFG_INV_COV_XX: cov_xx = data;
			gd2d_pkg::CFG_INV_COV_XY: cov_xy = data;
			gd2d_pkg::CFG_INV_COV_YY: cov_yy = data;
			gd2d_pkg::CFG_CENTER_X:   ctr_x  = data[11:0];
			gd2d_pkg::CFG_CENTER_Y:   ctr_y  = data[11:0];
			gd2d_pkg::CFG_GAIN:       gain_q = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Full register load, only with the pipeline empty.
	task automatic load_config(input logic [31:0] xx, input logic [31:0] xy,
			input logic [31:0] yy, input logic [11:0] cx, input logic [11:0] cy,
			input logic [15:0] g);
		drain_results();
		write_reg(gd2d_pkg::CFG_INV_COV_XX, xx);
		write_reg(gd2d_pkg::CFG_INV_COV_XY, xy);
		write_reg(gd2d_pkg::CFG_INV_COV_YY, yy);
		write_reg(gd2d_pkg::CFG_CENTER_X, {20'd0, cx});
		write_reg(gd2d_pkg::CFG_CENTER_Y, {20'd0, cy});
		write_reg(gd2d_pkg::CFG_GAIN, {16'd0, g});
	endtask

	// ------------------------------------------------------------------------
	// Output side: random backpressure bursts of stalled cycles
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left != 0 && !quiet) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (!quiet && stall_rate != 0
				&& $urandom_range(0, stall_rate - 1) == 0) begin
			stall_left <= $urandom_range(0, 14);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Result checker: each output transaction against the oldest prediction
	// ------------------------------------------------------------------------
	density_exp_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (density_q.size() == 0) begin
				errors++;
				$display("%0t: density expected none, actual %h", $time, density);
			end else begin
				want = density_q.pop_front();
				if (density !== want.density) begin
					errors++;
					$display("%0t: density at (%0d,%0d): expected %h, actual %h",
						$time, want.x, want.y, want.density, density);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset config: identity covariance, center 255/255, gain 5.0.
	task automatic test_reset_defaults();
		send_pixel(12'd255, 12'd255);    // peak, q = 0
		send_pixel(12'd256, 12'd255);
		send_pixel(12'd255, 12'd249);
		send_pixel(12'd0, 12'd0);        // far away -> zero
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'd0, 12'hFFF);
		send_pixel(12'hFFF, 12'd0);
	endtask

	// Register extremes: full-scale covariance entries, edge centers, max gain.
	task automatic test_register_extremes();
		load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			12'hFFF, 12'h000, 16'hFFFF);
		send_pixel(12'hFFF, 12'h000);
		send_pixel(12'h000, 12'hFFF);
		send_pixel(12'hFFE, 12'h001);
		send_pixel(12'h000, 12'h000);
	endtask

	// Indefinite matrix: negative q makes the value grow, then saturate.
	task automatic test_negative_quadratic();
		load_config(32'hFF00_0000, 32'd0, 32'h0100_0000,
			12'd2048, 12'd2048, 16'd1280);
		send_pixel(12'd2049, 12'd2048);  // q = -1, grows but in range
		send_pixel(12'd2058, 12'd2048);  // deep negative, clamped -> all ones
		send_pixel(12'd2050, 12'd2049);
		drain_results();
		write_reg(gd2d_pkg::CFG_GAIN, 32'd0);
		send_pixel(12'd2058, 12'd2048);  // zero gain stays zero even here
	endtask

	// Zero gain on an ordinary matrix.
	task automatic test_zero_gain();
		load_config(32'h0100_0000, 32'h0040_0000, 32'h0080_0000,
			12'd100, 12'd3000, 16'd0);
		send_pixel(12'd100, 12'd3000);
		send_pixel(12'd102, 12'd2999);
	endtask

	// Writes to indexes outside the map must leave every register alone.
	task automatic test_spare_index();
		drain_results();
		write_reg(gd2d_pkg::CFG_GAIN, 32'd256);
		write_reg(CFG_SPARE_6, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE_7, 32'hFFFF_FFFF);
		send_pixel(12'd100, 12'd3000);
		send_pixel(12'd101, 12'd3002);
		send_pixel(12'd98, 12'd3001);
	endtask

	// Random configurations, each followed by a burst of pixels. Most pixels
	// sit near the center so that the exp table and shifts get exercised.
	task automatic test_random_phases(input int phases, input int per_phase);
		logic [31:0] xx, xy, yy;
		logic [11:0] cx, cy, x, y;
		logic [15:0] g;
		int          r, span;
		for (int ph = 0; ph < phases; ph++) begin
			case ($urandom_range(0, 9))
				0: begin  // arbitrary bit patterns
					xx = $urandom;
					xy = $urandom;
					yy = $urandom;
				end
				1: begin  // indefinite: negative curvature along x
					xx = 32'd0 - $urandom_range(1 << 12, 1 << 26);
					yy = $urandom_range(1 << 12, 1 << 27);
					xy = $urandom_range(0, 1 << 20);
				end
				default: begin  // positive definite, sigma from ~0.35 to ~64 px
					xx = $urandom_range(1 << 12, 1 << 27);
					yy = $urandom_range(1 << 12, 1 << 27);
					span = int'(((xx < yy) ? xx : yy) / 2);
					xy = $urandom_range(0, 2 * span) - span;
				end
			endcase
			cx = $urandom;
			cy = $urandom;
			if ($urandom_range(0, 5) == 0) begin
				cx = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			end
			if ($urandom_range(0, 5) == 0) begin
				cy = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			end
			case ($urandom_range(0, 11))
				0:       g = 16'd0;
				1:       g = 16'hFFFF;
				default: g = $urandom;
			endcase
			if (ph == phases - 1) begin
				// last stretch runs with both sides always ready
				quiet = 1'b1;
			end else begin
				gap_rate   = $urandom_range(0, 3) * 2;
				stall_rate = $urandom_range(0, 3) * 3;
			end
			load_config(xx, xy, yy, cx, cy, g);
			for (int n = 0; n < per_phase; n++) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						x = $urandom;
						y = $urandom;
					end
					2: begin
						x = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
						y = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
					end
					default: begin
						// coordinates wrap at the 12-bit edge, as in the block
						r = 1 << $urandom_range(0, 9);
						x = ctr_x + $urandom_range(0, 2 * r) - r;
						y = ctr_y + $urandom_range(0, 2 * r) - r;
					end
				endcase
				send_pixel(x, y);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		fill_exp_table();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_negative_quadratic();
		test_zero_gain();
		test_spare_index();
		test_random_phases(10, 75);

		// pipeline is 12 deep; leave room for any stray output transaction
		drain_results();
		repeat (30) @(negedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (~1000 transactions with
	// worst-case gaps and stalls stays under 0.5 ms).
	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", density_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
